FILE: sv/node_presence_registry_defines.svh
// Assertion macros shared by the node presence registry RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef NODE_PRESENCE_REGISTRY_DEFINES_SVH
`define NODE_PRESENCE_REGISTRY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NPR_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPR_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/npr_pkg.sv
// Shared types and constants of the node presence registry.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package npr_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int NODE_W     = 16;
    localparam int SRC_W      = 8;
    localparam int AGE_W      = 16;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 5;
    localparam int IDENT_W    = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 29;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SOURCE = 2'd0,
        REG_LIVE_LIMIT  = 2'd1,
        REG_LOWEST_ID   = 2'd2,
        REG_ANNOUNCE_ID = 2'd3
    } npr_reg_t;

    typedef struct packed {
        logic [SRC_W-1:0]   base_source;
        logic [AGE_W-1:0]   live_limit;
        logic [NODE_W-1:0]  lowest_id;
        logic [IDENT_W-1:0] announce_id;
    } npr_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic age;
        logic load;
        logic scan;
        logic commit;
    } npr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic frame_hit;
        logic scan_last;
    } npr_status_t;

endpackage

FILE: sv/npr_cfg_regs.sv
// Configuration register file of the node presence registry.
// Depends on npr_pkg.
`timescale 1ns / 1ps

module npr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [npr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output npr_pkg::npr_cfg_t             cfg
);
    import npr_pkg::*;

    logic [SRC_W-1:0]   base_source_reg;
    logic [AGE_W-1:0]   live_limit_reg;
    logic [NODE_W-1:0]  lowest_id_reg;
    logic [IDENT_W-1:0] announce_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_source_reg <= SRC_W'(10);
            live_limit_reg  <= AGE_W'(6);
            lowest_id_reg   <= NODE_W'(1000);
            announce_id_reg <= IDENT_W'(921);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_SOURCE: base_source_reg <= cfg_wdata[SRC_W-1:0];
                REG_LIVE_LIMIT:  live_limit_reg  <= cfg_wdata[AGE_W-1:0];
                REG_LOWEST_ID:   lowest_id_reg   <= cfg_wdata[NODE_W-1:0];
                REG_ANNOUNCE_ID: announce_id_reg <= cfg_wdata[IDENT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.base_source = base_source_reg;
    assign cfg.live_limit  = live_limit_reg;
    assign cfg.lowest_id   = lowest_id_reg;
    assign cfg.announce_id = announce_id_reg;

endmodule

FILE: sv/npr_ctrl.sv
// Sequencer of the node presence registry: accept, scan, commit.
// Depends on npr_pkg.
`timescale 1ns / 1ps

module npr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  npr_pkg::npr_status_t st,
    output npr_pkg::npr_cmd_t    cmd_out,
    output logic                 busy
);
    import npr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } npr_state_t;

    npr_state_t state_reg;
    npr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_out    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (st.is_tick)
                        cmd_out.age = 1'b1;
                    else if (st.frame_hit)
                    begin
                        cmd_out.load = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd_out.scan = 1'b1;
                if (st.scan_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd_out.commit = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: sv/npr_datapath.sv
// Entry table, scan accumulators and result registers of the registry.
// Depends on npr_pkg; driven by npr_ctrl.
`timescale 1ns / 1ps

module npr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  npr_pkg::npr_cfg_t               cfg,
    input  npr_pkg::npr_cmd_t               cmd_in,
    output npr_pkg::npr_status_t            st,
    input  logic                            cmd,
    input  logic [npr_pkg::IDENT_W-1:0]     frame_ident,
    input  logic [7:0]                      data_low,
    input  logic [7:0]                      data_high,
    output logic                            done,
    output logic [npr_pkg::NODE_W-1:0]      node_id,
    output logic [npr_pkg::SUM_W-1:0]       live_id_sum,
    output logic [npr_pkg::CNT_W-1:0]       live_count,
    output logic [npr_pkg::SRC_W-1:0]       assigned_source
);
    import npr_pkg::*;

    // Entry table
    logic [NODE_W-1:0] node_reg  [ENTRIES];
    logic [SRC_W-1:0]  src_reg   [ENTRIES];
    logic [AGE_W-1:0]  age_reg   [ENTRIES];
    logic              valid_reg [ENTRIES];
    logic [IDX_W-1:0]  next_slot_reg;

    // Scan state
    logic [NODE_W-1:0] id_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              match_live_reg;
    logic              slot_live_reg;
    logic [NODE_W-1:0] slot_node_reg;

    // Result
    logic              done_reg;
    logic [NODE_W-1:0] out_id_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [SRC_W-1:0]  out_src_reg;

    logic [NODE_W-1:0] in_id;
    logic [NODE_W-1:0] rd_node;
    logic              rd_valid;
    logic              rd_live;
    logic              rd_match;
    logic [IDX_W-1:0]  target;
    logic              id_live;
    logic              old_live;
    logic [NODE_W-1:0] old_node;
    logic [SUM_W-1:0]  fin_sum;
    logic [CNT_W-1:0]  fin_cnt;
    logic [SRC_W-1:0]  fin_src;
    logic [IDX_W-1:0]  slot_inc;

    assign in_id = {data_high, data_low};

    assign st.is_tick   = cmd;
    assign st.frame_hit = (frame_ident == cfg.announce_id) && (in_id >= cfg.lowest_id);
    assign st.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));

    assign rd_node  = node_reg[scan_idx_reg];
    assign rd_valid = valid_reg[scan_idx_reg];
    assign rd_live  = rd_valid && (age_reg[scan_idx_reg] < cfg.live_limit);
    assign rd_match = rd_valid && (rd_node == id_reg);

    // Totals after the update: take out the entry being replaced or refreshed,
    // then add the new id back with age zero (live unless the limit is zero).
    assign target   = found_reg ? match_idx_reg : next_slot_reg;
    assign id_live  = (cfg.live_limit != '0);
    assign old_live = found_reg ? match_live_reg : slot_live_reg;
    assign old_node = found_reg ? id_reg : slot_node_reg;
    assign fin_sum  = sum_reg - (old_live ? SUM_W'(old_node) : '0)
                              + (id_live ? SUM_W'(id_reg) : '0);
    assign fin_cnt  = cnt_reg - (old_live ? CNT_W'(1) : '0)
                              + (id_live ? CNT_W'(1) : '0);
    assign fin_src  = found_reg ? src_reg[match_idx_reg]
                                : cfg.base_source + SRC_W'(next_slot_reg);
    assign slot_inc = (next_slot_reg == IDX_W'(ENTRIES - 1)) ? '0 : next_slot_reg + 1'b1;

    // Control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= 1'b0;
            next_slot_reg <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_in.commit;
            if (cmd_in.load)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd_in.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (rd_match)
                    found_reg <= 1'b1;
            end
            if (cmd_in.commit && !found_reg)
            begin
                valid_reg[next_slot_reg] <= 1'b1;
                next_slot_reg            <= slot_inc;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_in.age)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (age_reg[i] != AGE_MAX)
                    age_reg[i] <= age_reg[i] + 1'b1;
        end
        if (cmd_in.load)
        begin
            id_reg  <= in_id;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd_in.scan)
        begin
            if (rd_live)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_node);
                cnt_reg <= cnt_reg + 1'b1;
            end
            // keep the lowest matching index only
            if (rd_match && !found_reg)
            begin
                match_idx_reg  <= scan_idx_reg;
                match_live_reg <= rd_live;
            end
            if (scan_idx_reg == next_slot_reg)
            begin
                slot_live_reg <= rd_live;
                slot_node_reg <= rd_node;
            end
        end
        if (cmd_in.commit)
        begin
            age_reg[target] <= '0;
            if (!found_reg)
            begin
                node_reg[target] <= id_reg;
                src_reg[target]  <= fin_src;
            end
            out_id_reg  <= id_reg;
            out_sum_reg <= fin_sum;
            out_cnt_reg <= fin_cnt;
            out_src_reg <= fin_src;
        end
    end

    assign done            = done_reg;
    assign node_id         = out_id_reg;
    assign live_id_sum     = out_sum_reg;
    assign live_count      = out_cnt_reg;
    assign assigned_source = out_src_reg;

endmodule

FILE: sv/node_presence_registry.sv
// Top level of the node presence registry: config, sequencer and datapath.
// Depends on npr_pkg, npr_cfg_regs, npr_ctrl, npr_datapath and the defines header.
`timescale 1ns / 1ps
`include "node_presence_registry_defines.svh"

// Usage
//   Requests: drive cmd, frame_ident, data_low and data_high with start high;
//   the request is taken at a clock edge where start is high and busy is low.
//   A tick (cmd high) ages every entry at that edge and leaves busy low, so
//   ticks can come every cycle. A frame with another identifier or an id
//   below the minimum is dropped at that edge, also without busy.
//   An announcement raises busy: one pass over the table through a single
//   read port (one entry a cycle) gathers the match and the live totals,
//   then the commit state writes the update. done pulses for one cycle
//   right as busy falls, with node_id, live_id_sum, live_count and
//   assigned_source valid in that cycle and held until the next result.
//   The receiver cannot stall: take each result in its done cycle.
//   Configuration: write with cfg_we, cfg_index and cfg_wdata, only while
//   busy is low. Reset clears the table and the slot pointer at once and
//   loads the default register values; no clearing pass is needed.
module node_presence_registry (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [npr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cmd,
    input  logic [npr_pkg::IDENT_W-1:0]     frame_ident,
    input  logic [7:0]                      data_low,
    input  logic [7:0]                      data_high,
    output logic                            done,
    output logic [npr_pkg::NODE_W-1:0]      node_id,
    output logic [npr_pkg::SUM_W-1:0]       live_id_sum,
    output logic [npr_pkg::CNT_W-1:0]       live_count,
    output logic [npr_pkg::SRC_W-1:0]       assigned_source
);
    import npr_pkg::*;

    npr_cfg_t    cfg;
    npr_cmd_t    dp_cmd;
    npr_status_t dp_st;

    npr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    npr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .st      (dp_st),
        .cmd_out (dp_cmd),
        .busy    (busy)
    );

    npr_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd_in          (dp_cmd),
        .st              (dp_st),
        .cmd             (cmd),
        .frame_ident     (frame_ident),
        .data_low        (data_low),
        .data_high       (data_high),
        .done            (done),
        .node_id         (node_id),
        .live_id_sum     (live_id_sum),
        .live_count      (live_count),
        .assigned_source (assigned_source)
    );

    `NPR_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "done without a finished scan")
    `NPR_ASSERT_NEXT(a_tick_stays_idle, start && !busy && cmd, !busy && !done, "tick made the block busy")
    `NPR_ASSERT_NEXT(a_hit_goes_busy, start && !busy && !cmd && dp_st.frame_hit, busy, "announcement not taken")
    `NPR_ASSERT_NOW(a_count_bound, done, live_count <= CNT_W'(ENTRIES), "live count exceeds table size")

endmodule
